@@ hdl/gut_pkg.sv @@
// Shared types, constants and helper functions of the glyph upscale and transpose block.
package gut_pkg;

   // Default limits of the source glyph and of the magnification.
   localparam int MAX_WIDTH_DEF  = 32;
   localparam int MAX_HEIGHT_DEF = 32;
   localparam int MAX_SCALE_DEF  = 4;

   // Depths of the command queue and of the result queue.
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   // Store address width needed by the 6-bit geometry registers (31 * 63 + 31 < 2048).
   localparam int ADDR_W = 11;

   // Configuration register indexes.
   localparam int          CSR_INDEX_W      = 2;
   localparam logic [1:0]  CSR_GLYPH_WIDTH  = 2'd0;
   localparam logic [1:0]  CSR_GLYPH_HEIGHT = 2'd1;
   localparam logic [1:0]  CSR_SCALE        = 2'd2;

   // Register reset values.
   localparam logic [5:0] WIDTH_RESET  = 6'd6;
   localparam logic [5:0] HEIGHT_RESET = 6'd8;
   localparam logic [2:0] SCALE_RESET  = 3'd1;

   // Request function codes.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Nibble masks of a packed pixel byte.
   localparam logic [7:0] HI_MASK = 8'hF0;
   localparam logic [7:0] LO_MASK = 8'h0F;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      logic              is_read;
      logic              oor;
      logic              odd_col;
      logic [ADDR_W-1:0] addr_lo;
      logic [ADDR_W-1:0] addr_hi;
      logic [7:0]        load_byte;
   } cmd_type;

   // Result transaction.
   typedef struct packed {
      logic [7:0] pixel_pair;
      logic       out_of_range;
   } rsp_type;

   // Divide a 7-bit coordinate by a scale of 1 to 4; a third is a reciprocal multiply.
   function automatic logic [6:0] div_by_scale(input logic [6:0] v, input logic [2:0] s);
      logic [15:0] prod;
      logic [6:0]  q;
      prod = 16'(v) * 16'd171;
      case (s)
         3'd1:    q = v;
         3'd2:    q = v >> 1;
         3'd3:    q = prod[15:9];
         3'd4:    q = v >> 2;
         default: q = v;
      endcase
      return q;
   endfunction

   // Select one pixel of a packed byte: the even pixel sits in the high nibble.
   function automatic logic [3:0] pick_pixel(input logic [7:0] b, input logic odd);
      logic [7:0] hi_part;
      logic [7:0] lo_part;
      hi_part = (b & HI_MASK) >> 4;
      lo_part = b & LO_MASK;
      return odd ? lo_part[3:0] : hi_part[3:0];
   endfunction

endpackage

@@ hdl/glyph_upscale_transpose_4bpp_top.sv @@
// A transaction accepted on the request ports passes through front stages one and two, the
// command queue, the registered store read and the result queue before it can be taken.
// Throughput: one transaction per cycle, loads and reads mixed freely, with no bubbles while
// results are popped as they arrive; a full result queue holds the back end and then the requests.
// Reset is synchronous and active high; it empties both queues and the pipeline, and restores
// a 6 x 8 glyph at scale 1. The glyph store is not cleared: read only entries already loaded.
module glyph_upscale_transpose_4bpp_top #(
   parameter int MAX_WIDTH  = gut_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gut_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_SCALE  = gut_pkg::MAX_SCALE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_func,
   input  logic [8:0]                      req_load_addr,
   input  logic [7:0]                      req_load_byte,
   input  logic [6:0]                      req_out_column,
   input  logic [5:0]                      req_out_pair,
   // Result channel.
   input  logic                            rsp_pop,
   output logic                            rsp_empty,
   output logic [7:0]                      rsp_pixel_pair,
   output logic                            rsp_out_of_range,
   // Configuration write channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gut_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata
);

   // The store holds half a row of bytes for every row of the largest glyph.
   localparam int STORE_DEPTH = (MAX_WIDTH / 2) * MAX_HEIGHT;
   localparam int CMD_CW      = $clog2(gut_pkg::CMD_DEPTH + 1);
   localparam int RSP_CW      = $clog2(gut_pkg::RSP_DEPTH + 1);

   logic                  cmd_push, cmd_pop, cmd_empty;
   logic [CMD_CW-1:0]     cmd_count;
   gut_pkg::cmd_type      cmd_in, cmd_out;

   logic                  rsp_push;
   logic [RSP_CW-1:0]     rsp_count;
   gut_pkg::rsp_type      rsp_in, rsp_out;

   // Register writes are always taken; they are legal only while the block is idle.
   assign csr_ready = 1'b1;

   // The front end checks bounds, divides the coordinates by the scale and forms the
   // row-major byte addresses of the two source rows that feed one output byte.
   gut_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_SCALE  (MAX_SCALE),
      .CMD_DEPTH  (gut_pkg::CMD_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_load_addr  (req_load_addr),
      .req_load_byte  (req_load_byte),
      .req_out_column (req_out_column),
      .req_out_pair   (req_out_pair),
      .csr_write      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd_count      (cmd_count),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_in)
   );

   // The command queue decouples classification from the store accesses. The front end
   // holds credits for it, so a push never meets a full queue.
   gut_fifo #(
      .WIDTH ($bits(gut_pkg::cmd_type)),
      .DEPTH (gut_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   // The back end performs loads and reads in command order, so a read always sees
   // every load that was accepted before it.
   gut_back #(
      .STORE_DEPTH (STORE_DEPTH),
      .RSP_DEPTH   (gut_pkg::RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in)
   );

   // The result queue lets new requests flow while the consumer stalls.
   gut_fifo #(
      .WIDTH ($bits(gut_pkg::rsp_type)),
      .DEPTH (gut_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .pop       (rsp_pop),
      .pop_data  (rsp_out),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   assign rsp_pixel_pair   = rsp_out.pixel_pair;
   assign rsp_out_of_range = rsp_out.out_of_range;

   // The front-end credit count must keep the command queue from overflowing.
   assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (32'(cmd_count) < gut_pkg::CMD_DEPTH))
      else $error("command queue pushed while full");

   // The back end must never write a result into a full result queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (32'(rsp_count) < gut_pkg::RSP_DEPTH))
      else $error("result queue pushed while full");

   // Every out-of-range transaction, load or read, carries a zero pixel pair.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_out_of_range) |-> (rsp_pixel_pair == 8'd0))
      else $error("out-of-range result with nonzero pixel data");

   // A command leaves the queue only when one is waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command popped from an empty queue");

endmodule

@@ hdl/gut_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gut_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/gut_fifo.sv @@
// Small register-based first-in first-out queue with an occupancy count.
module gut_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

@@ hdl/gut_front.sv @@
// Front end: geometry registers, request classification and store address generation.
module gut_front #(
   parameter int MAX_WIDTH  = gut_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gut_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_SCALE  = gut_pkg::MAX_SCALE_DEF,
   parameter int CMD_DEPTH  = gut_pkg::CMD_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_func,
   input  logic [8:0]                        req_load_addr,
   input  logic [7:0]                        req_load_byte,
   input  logic [6:0]                        req_out_column,
   input  logic [5:0]                        req_out_pair,
   input  logic                              csr_write,
   input  logic [gut_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_wdata,
   input  logic [$clog2(CMD_DEPTH+1)-1:0]    cmd_count,
   output logic                              cmd_push,
   output gut_pkg::cmd_type                  cmd_data
);

   localparam int STORE_DEPTH = (MAX_WIDTH / 2) * MAX_HEIGHT;

   typedef struct packed {
      logic       is_read;
      logic       oor;
      logic [8:0] load_addr;
      logic [7:0] load_byte;
      logic [6:0] sx;
      logic [6:0] sy_lo;
      logic [6:0] sy_hi;
   } stage_type;

   logic [5:0] width_ff, width_in;
   logic [5:0] height_ff, height_in;
   logic [2:0] scale_ff, scale_in;

   logic       s1_v_ff, s2_v_ff;
   stage_type  s1_ff, s1_in;
   gut_pkg::cmd_type s2_ff, s2_in;

   logic       accept;
   logic [8:0] scaled_w, scaled_h;
   logic [6:0] row_lo, row_hi;
   logic [11:0] load_limit;
   logic [4:0] half_w;
   logic [5:0] wv, hv;
   logic [2:0] sv;

   // Geometry registers; illegal values are dropped.
   assign wv = csr_wdata[5:0];
   assign hv = csr_wdata[5:0];
   assign sv = csr_wdata[2:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      scale_in  = scale_ff;
      if (csr_write) begin
         case (csr_index)
            gut_pkg::CSR_GLYPH_WIDTH: begin
               if (wv >= 6'd2 && 32'(wv) <= MAX_WIDTH && !wv[0]) begin
                  width_in = wv;
               end
            end
            gut_pkg::CSR_GLYPH_HEIGHT: begin
               if (hv >= 6'd2 && 32'(hv) <= MAX_HEIGHT && !hv[0]) begin
                  height_in = hv;
               end
            end
            gut_pkg::CSR_SCALE: begin
               if (sv >= 3'd1 && 32'(sv) <= MAX_SCALE) begin
                  scale_in = sv;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Credits: queued commands plus those still in the two front stages.
   assign req_full = (32'(cmd_count) + 32'(s1_v_ff) + 32'(s2_v_ff)) >= CMD_DEPTH;
   assign accept   = req_push && !req_full;

   // Stage one: bounds checks and division of the coordinates by the scale.
   assign scaled_w   = 9'(width_ff) * 9'(scale_ff);
   assign scaled_h   = 9'(height_ff) * 9'(scale_ff);
   assign row_lo     = {req_out_pair, 1'b0};
   assign row_hi     = {req_out_pair, 1'b1};
   assign load_limit = 12'(width_ff[5:1]) * 12'(height_ff);

   always_comb begin
      s1_in.is_read   = (req_func == gut_pkg::FUNC_READ);
      s1_in.load_addr = req_load_addr;
      s1_in.load_byte = req_load_byte;
      s1_in.sx        = gut_pkg::div_by_scale(req_out_column, scale_ff);
      s1_in.sy_lo     = gut_pkg::div_by_scale(row_lo, scale_ff);
      s1_in.sy_hi     = gut_pkg::div_by_scale(row_hi, scale_ff);
      if (req_func == gut_pkg::FUNC_READ) begin
         s1_in.oor = (9'(req_out_column) >= scaled_w) || (9'(row_hi) >= scaled_h);
      end else begin
         s1_in.oor = (12'(req_load_addr) >= load_limit) ||
                     (32'(req_load_addr) >= STORE_DEPTH);
      end
   end

   // Stage two: row-major byte addresses of the two source rows.
   assign half_w = width_ff[5:1];

   always_comb begin
      s2_in.is_read   = s1_ff.is_read;
      s2_in.oor       = s1_ff.oor;
      s2_in.odd_col   = s1_ff.sx[0];
      s2_in.load_byte = s1_ff.load_byte;
      if (s1_ff.is_read) begin
         s2_in.addr_lo = gut_pkg::ADDR_W'(12'(s1_ff.sy_lo) * 12'(half_w)) +
                         gut_pkg::ADDR_W'(s1_ff.sx[6:1]);
         s2_in.addr_hi = gut_pkg::ADDR_W'(12'(s1_ff.sy_hi) * 12'(half_w)) +
                         gut_pkg::ADDR_W'(s1_ff.sx[6:1]);
      end else begin
         s2_in.addr_lo = gut_pkg::ADDR_W'(s1_ff.load_addr);
         s2_in.addr_hi = gut_pkg::ADDR_W'(s1_ff.load_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gut_pkg::WIDTH_RESET;
         height_ff <= gut_pkg::HEIGHT_RESET;
         scale_ff  <= gut_pkg::SCALE_RESET;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         scale_ff  <= scale_in;
         s1_v_ff   <= accept;
         s2_v_ff   <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign cmd_push = s2_v_ff;
   assign cmd_data = s2_ff;

endmodule

@@ hdl/gut_back.sv @@
// Back end: glyph store, store reads for both rows and result assembly.
module gut_back #(
   parameter int STORE_DEPTH = (gut_pkg::MAX_WIDTH_DEF / 2) * gut_pkg::MAX_HEIGHT_DEF,
   parameter int RSP_DEPTH   = gut_pkg::RSP_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_empty,
   input  gut_pkg::cmd_type               cmd_data,
   output logic                           cmd_pop,
   input  logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count,
   output logic                           rsp_push,
   output gut_pkg::rsp_type               rsp_data
);

   localparam int AW = $clog2(STORE_DEPTH);

   logic          issue;
   logic          wr_en, rd_en;
   logic [7:0]    lo_data, hi_data;
   logic          rd_v_ff;
   logic          rd_keep_ff, rd_oor_ff, rd_odd_ff;

   // Issue only when the result queue has room for everything in flight.
   assign issue = !cmd_empty && ((32'(rsp_count) + 32'(rd_v_ff)) < RSP_DEPTH);
   assign wr_en = issue && !cmd_data.is_read && !cmd_data.oor;
   assign rd_en = issue && cmd_data.is_read && !cmd_data.oor;

   // Both copies take every load so each can serve one source row per cycle.
   gut_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store_lo (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(cmd_data.addr_lo)),
      .wr_data (cmd_data.load_byte),
      .rd_en   (rd_en),
      .rd_addr (AW'(cmd_data.addr_lo)),
      .rd_data (lo_data)
   );

   gut_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store_hi (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(cmd_data.addr_lo)),
      .wr_data (cmd_data.load_byte),
      .rd_en   (rd_en),
      .rd_addr (AW'(cmd_data.addr_hi)),
      .rd_data (hi_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_keep_ff <= cmd_data.is_read && !cmd_data.oor;
         rd_oor_ff  <= cmd_data.oor;
         rd_odd_ff  <= cmd_data.odd_col;
      end
   end

   assign cmd_pop  = issue;
   assign rsp_push = rd_v_ff;

   always_comb begin
      rsp_data.out_of_range = rd_oor_ff;
      if (rd_keep_ff) begin
         rsp_data.pixel_pair = {gut_pkg::pick_pixel(hi_data, rd_odd_ff),
                                gut_pkg::pick_pixel(lo_data, rd_odd_ff)};
      end else begin
         rsp_data.pixel_pair = '0;
      end
   end

endmodule

@@ sim/glyph_upscale_transpose_4bpp_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts and compares the results of the glyph upscale and transpose block.
module glyph_upscale_transpose_4bpp_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  logic                            req_full,
   input  logic                            req_func,
   input  logic [8:0]                      req_load_addr,
   input  logic [7:0]                      req_load_byte,
   input  logic [6:0]                      req_out_column,
   input  logic [5:0]                      req_out_pair,
   input  logic                            rsp_pop,
   input  logic                            rsp_empty,
   input  logic [7:0]                      rsp_pixel_pair,
   input  logic                            rsp_out_of_range,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [gut_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_wdata,
   output int                              fail_count,
   output int                              pending_count
);
   import gut_pkg::*;

   localparam int STORE_DEPTH  = (MAX_WIDTH_DEF / 2) * MAX_HEIGHT_DEF;
   localparam int REPORT_LIMIT = 40;

   logic [7:0] glyph_copy [STORE_DEPTH];
   int         glyph_w;
   int         glyph_h;
   int         zoom;
   rsp_type    expected_pixels [$];
   int         errors = 0;

   // Pixel at source coordinates; the even pixel of a byte sits in the high nibble.
   function automatic logic [3:0] glyph_pixel(input int sx, input int sy);
      logic [7:0] b;
      b = glyph_copy[sy * (glyph_w / 2) + sx / 2];
      return sx[0] ? b[3:0] : b[7:4];
   endfunction

   // Loads update the glyph copy; reads sample rows 2n and 2n+1 of the scaled image.
   function automatic rsp_type predict_pixel_pair(input logic func, input logic [8:0] addr,
                                                  input logic [7:0] data, input logic [6:0] col,
                                                  input logic [5:0] pair);
      rsp_type r;
      int      y0;
      int      sx;
      r.pixel_pair   = 8'h00;
      r.out_of_range = 1'b0;
      y0             = 2 * int'(pair);
      if (func == FUNC_LOAD) begin
         if (int'(addr) >= (glyph_w / 2) * glyph_h)
            r.out_of_range = 1'b1;
         else
            glyph_copy[addr] = data;
      end else if (int'(col) >= glyph_w * zoom || y0 + 1 >= glyph_h * zoom) begin
         r.out_of_range = 1'b1;
      end else begin
         sx           = int'(col) / zoom;
         r.pixel_pair = {glyph_pixel(sx, (y0 + 1) / zoom), glyph_pixel(sx, y0 / zoom)};
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         glyph_w = WIDTH_RESET;
         glyph_h = HEIGHT_RESET;
         zoom    = SCALE_RESET;
         expected_pixels.delete();
      end else begin
         // Writes of illegal values leave the register as it was.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GLYPH_WIDTH: begin
                  if (csr_wdata[5:0] >= 2 && csr_wdata[5:0] <= MAX_WIDTH_DEF && !csr_wdata[0])
                     glyph_w = csr_wdata[5:0];
               end
               CSR_GLYPH_HEIGHT: begin
                  if (csr_wdata[5:0] >= 2 && csr_wdata[5:0] <= MAX_HEIGHT_DEF && !csr_wdata[0])
                     glyph_h = csr_wdata[5:0];
               end
               CSR_SCALE: begin
                  if (csr_wdata[2:0] >= 1 && csr_wdata[2:0] <= MAX_SCALE_DEF)
                     zoom = csr_wdata[2:0];
               end
               default: ;
            endcase
         end
         if (req_push && !req_full)
            expected_pixels.push_back(predict_pixel_pair(req_func, req_load_addr, req_load_byte,
                                                         req_out_column, req_out_pair));
         if (rsp_pop && !rsp_empty) begin
            if (expected_pixels.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("%0t: unexpected result transaction: expected none, actual %02h/%0b",
                           $time, rsp_pixel_pair, rsp_out_of_range);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               if (want.pixel_pair !== rsp_pixel_pair) begin
                  if (errors < REPORT_LIMIT)
                     $display("%0t: pixel_pair mismatch: expected %02h, actual %02h",
                              $time, want.pixel_pair, rsp_pixel_pair);
                  errors++;
               end
               if (want.out_of_range !== rsp_out_of_range) begin
                  if (errors < REPORT_LIMIT)
                     $display("%0t: out_of_range mismatch: expected %0b, actual %0b",
                              $time, want.out_of_range, rsp_out_of_range);
                  errors++;
               end
            end
         end
      end
      fail_count    <= errors;
      pending_count <= expected_pixels.size();
   end

endmodule

@@ sim/glyph_upscale_transpose_4bpp_top_test.sv @@
`timescale 1ns / 1ps
// Testbench top: stimulus, response pacing and verdict for the glyph upscale and transpose block.
module glyph_upscale_transpose_4bpp_top_test;
   import gut_pkg::*;

   localparam int RESET_CYCLES   = 9;
   // Margin over the path from acceptance to the result ports of the block.
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 130;
   localparam int STORE_DEPTH    = (MAX_WIDTH_DEF / 2) * MAX_HEIGHT_DEF;
   // Register index that maps to no register; writes to it must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG = 2'd3;

   typedef enum int {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_EVERY_THIRD} pop_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic                   req_func;
   logic [8:0]             req_load_addr;
   logic [7:0]             req_load_byte;
   logic [6:0]             req_out_column;
   logic [5:0]             req_out_pair;
   logic                   rsp_pop;
   logic                   rsp_empty;
   logic [7:0]             rsp_pixel_pair;
   logic                   rsp_out_of_range;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   int   fail_count;
   int   pending_count;
   int   idle_cycles = 0;

   // Stimulus-side view of the block: the geometry in force and which store bytes hold data.
   // Reads are only issued once every store byte they touch has been loaded.
   logic loaded [STORE_DEPTH];
   int   cur_w;
   int   cur_h;
   int   cur_s;
   int   burst_left;
   // Set by the stimulus process to ask the receiver for one long hold-off.
   logic rsp_hold_req;

   glyph_upscale_transpose_4bpp_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_load_addr    (req_load_addr),
      .req_load_byte    (req_load_byte),
      .req_out_column   (req_out_column),
      .req_out_pair     (req_out_pair),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pixel_pair   (rsp_pixel_pair),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   glyph_upscale_transpose_4bpp_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_load_addr    (req_load_addr),
      .req_load_byte    (req_load_byte),
      .req_out_column   (req_out_column),
      .req_out_pair     (req_out_pair),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pixel_pair   (rsp_pixel_pair),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always #1 clock = ~clock;

   // Offers one request transaction and returns at the edge that accepts it. The sender works
   // in bursts: when a burst is used up, a new length is drawn and, most of the time, a gap of
   // idle cycles is inserted first. The request valid is only lowered at the start of a gap,
   // so it never gets two assignments in one time step.
   task automatic send_item(input logic func, input logic [8:0] addr, input logic [7:0] data,
                            input logic [6:0] col, input logic [5:0] pair);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_push       <= 1'b1;
      req_func       <= func;
      req_load_addr  <= addr;
      req_load_byte  <= data;
      req_out_column <= col;
      req_out_pair   <= pair;
      @(posedge clock);
      while (req_full) @(posedge clock);
      burst_left--;
   endtask

   // A load inside the configured glyph lands in the store; one outside is dropped by the block.
   // Read-side fields carry random values since the block must ignore them.
   task automatic load_glyph_byte(input int addr, input logic [7:0] data);
      if (addr < (cur_w / 2) * cur_h)
         loaded[addr] = 1'b1;
      send_item(FUNC_LOAD, addr[8:0], data, 7'($urandom), 6'($urandom));
   endtask

   // For a read inside the scaled image, the two store bytes that feed it are loaded first
   // with random content if nothing was written there yet. Reads outside touch no byte.
   task automatic read_pixel_pair(input int col, input int pair);
      int sx;
      int row;
      int a;
      if (col < cur_w * cur_s && 2 * pair < cur_h * cur_s) begin
         sx = col / cur_s;
         for (int k = 0; k < 2; k++) begin
            row = (2 * pair + k) / cur_s;
            a   = row * (cur_w / 2) + sx / 2;
            if (!loaded[a])
               load_glyph_byte(a, 8'($urandom));
         end
      end
      send_item(FUNC_READ, 9'($urandom), 8'($urandom), col[6:0], pair[5:0]);
   endtask

   // One register write transaction. The caller lowers the valid after its last write.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Changes the geometry once the block has gone idle. The bits above each register's width
   // are random, since the block must ignore them. A few writes that must be rejected follow,
   // so the new geometry has to survive them. The pending count is trusted only after the next
   // edge, so that a transaction accepted at the current edge is already counted.
   task automatic set_geometry(input int w, input int h, input int s);
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(CSR_GLYPH_WIDTH, {2'($urandom), 6'(w)});
      csr_write(CSR_GLYPH_HEIGHT, {2'($urandom), 6'(h)});
      csr_write(CSR_SCALE, {5'($urandom), 3'(s)});
      repeat (3) begin
         case ($urandom_range(0, 4))
            0: csr_write(CSR_GLYPH_WIDTH, {2'($urandom), 5'($urandom), 1'b1});
            1: csr_write(CSR_GLYPH_WIDTH,
                         {2'($urandom), ($urandom_range(0, 1) == 0) ? 6'd0
                                                                    : 6'($urandom_range(33, 63))});
            2: csr_write(CSR_GLYPH_HEIGHT, {2'($urandom), 6'($urandom_range(33, 63))});
            3: csr_write(CSR_SCALE,
                         {5'($urandom), ($urandom_range(0, 3) == 0) ? 3'd0
                                                                    : 3'($urandom_range(5, 7))});
            default: csr_write(CSR_NO_REG, 8'($urandom));
         endcase
      end
      csr_valid <= 1'b0;
      cur_w = w;
      cur_h = h;
      cur_s = s;
   endtask

   // Receiver: pops on a random pattern, redrawn whenever its stretch runs out, from popping
   // every cycle to popping rarely. On request it holds off for a long stretch so that the block
   // fills up and pushes back on the sender.
   initial begin : receiver
      pop_mode_type mode;
      int           mode_left;
      mode      = POP_ALWAYS;
      mode_left = 0;
      rsp_pop   = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_pop     <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = pop_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (mode)
               POP_ALWAYS: rsp_pop <= 1'b1;
               POP_HALF:   rsp_pop <= 1'($urandom_range(0, 1));
               POP_SPARSE: rsp_pop <= ($urandom_range(0, 3) == 0);
               default:    rsp_pop <= (mode_left % 3 == 0);
            endcase
         end
      end
   end

   // Watchdog: the run is declared failed when no transaction of any channel completes for a
   // long time. The longest legal quiet spell is the receiver hold-off plus a drain pause.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction completed for %0d cycles", $time, idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int items_left;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_func       = FUNC_LOAD;
      req_load_addr  = '0;
      req_load_byte  = '0;
      req_out_column = '0;
      req_out_pair   = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_GLYPH_WIDTH;
      csr_wdata      = '0;
      rsp_hold_req   = 1'b0;
      burst_left     = 0;
      cur_w          = WIDTH_RESET;
      cur_h          = HEIGHT_RESET;
      cur_s          = SCALE_RESET;
      foreach (loaded[i]) loaded[i] = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset geometry, 6 x 8 at scale 1, whose store holds 24 bytes.
      load_glyph_byte(0, 8'hFF);
      load_glyph_byte(23, 8'h00);     // last byte inside the glyph
      load_glyph_byte(24, 8'h5A);     // first byte past the glyph: flagged and dropped
      load_glyph_byte(511, 8'hA5);    // highest address, far outside
      read_pixel_pair(0, 0);
      read_pixel_pair(5, 3);          // bottom right corner
      read_pixel_pair(6, 0);          // one column past the right edge
      read_pixel_pair(0, 4);          // one row pair past the bottom
      read_pixel_pair(127, 63);       // both coordinates at their maximum

      // Smallest glyph; then writes that must all be rejected: odd width, zero width once the
      // upper bits are dropped, height above the maximum, scale zero and five, unknown index.
      set_geometry(2, 2, 1);
      @(posedge clock);
      csr_write(CSR_GLYPH_WIDTH, 8'h07);
      csr_write(CSR_GLYPH_WIDTH, 8'hC0);
      csr_write(CSR_GLYPH_HEIGHT, 8'h22);
      csr_write(CSR_SCALE, 8'h00);
      csr_write(CSR_SCALE, 8'h05);
      csr_write(CSR_NO_REG, 8'hFF);
      csr_valid <= 1'b0;
      load_glyph_byte(0, 8'h3C);
      read_pixel_pair(0, 0);
      read_pixel_pair(1, 0);
      read_pixel_pair(2, 0);
      load_glyph_byte(1, 8'h81);

      // Largest glyph at the largest scale: the scaled image spans every column and row pair.
      set_geometry(32, 32, 4);
      read_pixel_pair(127, 63);
      load_glyph_byte(511, 8'h96);
      read_pixel_pair(0, 0);

      // Scale three exercises the only division that is not a shift.
      set_geometry(32, 32, 3);
      read_pixel_pair(95, 47);
      read_pixel_pair(96, 0);
      read_pixel_pair(0, 48);

      // Random phases: a third loads, the rest reads. Most land inside the configured glyph,
      // the rest anywhere in the field ranges. Two phases start with a receiver hold-off.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       set_geometry(32, 32, 4);
            1:       set_geometry(2, 2, 1);
            2:       set_geometry(32, 2, 3);
            3:       set_geometry(2, 32, 2);
            default: set_geometry(2 * $urandom_range(1, 16), 2 * $urandom_range(1, 16),
                                  $urandom_range(1, MAX_SCALE_DEF));
         endcase
         if (p == 1 || p == 4)
            rsp_hold_req = 1'b1;
         items_left = PHASE_ITEMS;
         while (items_left > 0) begin
            if ($urandom_range(0, 99) < 35) begin
               if ($urandom_range(0, 9) == 0)
                  load_glyph_byte($urandom_range(0, STORE_DEPTH - 1), 8'($urandom));
               else
                  load_glyph_byte($urandom_range(0, (cur_w / 2) * cur_h - 1), 8'($urandom));
            end else if ($urandom_range(0, 9) == 0) begin
               read_pixel_pair($urandom_range(0, 127), $urandom_range(0, 63));
            end else begin
               read_pixel_pair($urandom_range(0, cur_w * cur_s - 1),
                               $urandom_range(0, cur_h * cur_s / 2 - 1));
            end
            items_left--;
         end
      end

      // Let every expected result arrive, then give the block time to show any extra one.
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ glyph_upscale_transpose_4bpp_top.f @@
hdl/gut_pkg.sv
hdl/gut_ram.sv
hdl/gut_fifo.sv
hdl/gut_front.sv
hdl/gut_back.sv
hdl/glyph_upscale_transpose_4bpp_top.sv
sim/glyph_upscale_transpose_4bpp_checker.sv
sim/glyph_upscale_transpose_4bpp_top_test.sv
